// ----- design/box_wall_reflect_impulse_assert.svh -----
// assertion macros for the box wall reflection block
// needs nothing else; included by box_wall_reflect_impulse.sv
`ifndef BOX_WALL_REFLECT_IMPULSE_ASSERT_SVH
`define BOX_WALL_REFLECT_IMPULSE_ASSERT_SVH

// same-cycle implication, held off during reset
`define BWRI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bwri check failed");

// next-cycle implication, held off during reset
`define BWRI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bwri check failed");

`endif

// ----- design/bwri_pkg.sv -----
// shared constants and helpers for the box wall reflection block
// no dependencies
package bwri_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int HALF_WIDTH      = 31;
   localparam int MASS_WIDTH      = 16;
   localparam int IMP_WIDTH       = 62;
   localparam int NUM_AXES        = 3;
   localparam int CSR_IDX_WIDTH   = 2;

   localparam logic [HALF_WIDTH-1:0] HALF_RESET = HALF_WIDTH'(65536);
   localparam logic [IMP_WIDTH-1:0]  IMP_MAX    = {IMP_WIDTH{1'b1}};

   // register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOX_HALF_X = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOX_HALF_Y = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOX_HALF_Z = 2'd2;

   typedef logic [IMP_WIDTH-1:0] imp_type;

   // saturating add of two impulse values, both below 2^62
   function automatic imp_type sat_add_imp(input imp_type a, input imp_type b);
      logic [IMP_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[IMP_WIDTH] ? IMP_MAX : sum[IMP_WIDTH-1:0];
   endfunction

endpackage

// ----- design/bwri_axis.sv -----
// one axis of the wall reflection: mirror, velocity flip, impulse product
// depends on bwri_pkg
module bwri_axis
   import bwri_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic signed [COORD_WIDTH-1:0] pos,
   input  logic signed [COORD_WIDTH-1:0] vel,
   input  logic        [HALF_WIDTH-1:0]  half,
   input  logic        [MASS_WIDTH-1:0]  mass,
   output logic signed [COORD_WIDTH-1:0] new_pos,
   output logic signed [COORD_WIDTH-1:0] new_vel,
   output logic        [IMP_WIDTH-1:0]   impulse
);

   localparam int EXT_W  = ((COORD_WIDTH > HALF_WIDTH + 1) ? COORD_WIDTH : HALF_WIDTH + 1) + 3;
   localparam int PROD_W = COORD_WIDTH + MASS_WIDTH + 1;
   localparam int WIDE_W = PROD_W + IMP_WIDTH;

   localparam logic signed [EXT_W-1:0] COORD_MAX_EXT =
      {{(EXT_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [EXT_W-1:0] COORD_MIN_EXT =
      {{(EXT_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   logic signed [EXT_W-1:0]       pos_ext, vel_ext, half_ext, two_half;
   logic signed [EXT_W-1:0]       mirror, vel_neg;
   logic                          hit_hi, hit_lo, hit;
   logic [COORD_WIDTH-1:0]        mag;
   logic [COORD_WIDTH+MASS_WIDTH-1:0] prod;
   logic [WIDE_W-1:0]             imp_wide;

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [EXT_W-1:0] x);
      if (x > COORD_MAX_EXT) begin
         return COORD_MAX_EXT[COORD_WIDTH-1:0];
      end else if (x < COORD_MIN_EXT) begin
         return COORD_MIN_EXT[COORD_WIDTH-1:0];
      end
      return x[COORD_WIDTH-1:0];
   endfunction

   always_comb begin
      pos_ext  = {{(EXT_W-COORD_WIDTH){pos[COORD_WIDTH-1]}}, pos};
      vel_ext  = {{(EXT_W-COORD_WIDTH){vel[COORD_WIDTH-1]}}, vel};
      half_ext = {{(EXT_W-HALF_WIDTH){1'b0}}, half};
      two_half = half_ext <<< 1;

      // on the wall counts as inside
      hit_hi = pos_ext > half_ext;
      hit_lo = pos_ext < -half_ext;
      hit    = hit_hi || hit_lo;

      mirror  = hit_hi ? (two_half - pos_ext) : (-two_half - pos_ext);
      vel_neg = -vel_ext;

      // most negative velocity gives the exact magnitude 2^(w-1)
      mag  = vel[COORD_WIDTH-1] ? vel_neg[COORD_WIDTH-1:0] : vel;
      prod = mag * mass;
      imp_wide = {{IMP_WIDTH{1'b0}}, prod, 1'b0};

      new_pos = hit ? sat_coord(mirror) : pos;
      new_vel = hit ? sat_coord(vel_neg) : vel;
      if (!hit) begin
         impulse = '0;
      end else if (imp_wide[WIDE_W-1:IMP_WIDTH] != '0) begin
         impulse = IMP_MAX;
      end else begin
         impulse = imp_wide[IMP_WIDTH-1:0];
      end
   end

endmodule

// ----- design/box_wall_reflect_impulse.sv -----
// top level of the box wall reflection block
// depends on bwri_pkg, bwri_axis and box_wall_reflect_impulse_assert.svh
//
// usage:
//   req_* channel takes one particle per item (position, velocity, mass and
//   a last flag); rsp_* channel gives one result item per particle with the
//   mirrored position and velocity. the particle marked last also carries
//   the three wall impulse totals (including its own hit) and clears them.
//   csr_* writes the box half-extents; write only while the block is idle.
// timing:
//   three register stages: input register, product register, result
//   register. rsp_valid rises when an accepted item has passed the input
//   and product registers and is loaded into the result register.
//   one item per cycle while rsp_ready is high; the impulse accumulators
//   add in the last stage so consecutive items chain without bubbles.
// reset:
//   synchronous, clears all valid flags and impulse sums, half-extents
//   return to 1.0 (65536 in Q16.16).
// stall:
//   each stage holds while the stage after it is full and blocked, so
//   bubbles close up and req_ready stays high until all three stages fill.
`include "box_wall_reflect_impulse_assert.svh"

module box_wall_reflect_impulse
   import bwri_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [COORD_WIDTH-1:0]  req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]  req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]  req_pos_z,
   input  logic signed [COORD_WIDTH-1:0]  req_vel_x,
   input  logic signed [COORD_WIDTH-1:0]  req_vel_y,
   input  logic signed [COORD_WIDTH-1:0]  req_vel_z,
   input  logic        [MASS_WIDTH-1:0]   req_mass,
   input  logic                           req_last_particle,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [COORD_WIDTH-1:0]  rsp_new_pos_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_new_pos_y,
   output logic signed [COORD_WIDTH-1:0]  rsp_new_pos_z,
   output logic signed [COORD_WIDTH-1:0]  rsp_new_vel_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_new_vel_y,
   output logic signed [COORD_WIDTH-1:0]  rsp_new_vel_z,
   output logic        [IMP_WIDTH-1:0]    rsp_impulse_x,
   output logic        [IMP_WIDTH-1:0]    rsp_impulse_y,
   output logic        [IMP_WIDTH-1:0]    rsp_impulse_z,
   output logic                           rsp_is_last,

   input  logic                           csr_write_en,
   input  logic        [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic        [HALF_WIDTH-1:0]   csr_wdata
);

   // box half-extents, one per axis
   logic [HALF_WIDTH-1:0] half_ff [NUM_AXES];
   logic [HALF_WIDTH-1:0] half_in [NUM_AXES];

   // stage 1: input register
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [COORD_WIDTH-1:0] s1_pos_ff [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] s1_vel_ff [NUM_AXES];
   logic [MASS_WIDTH-1:0]         s1_mass_ff;
   logic                          s1_last_ff;

   // stage 2: reflected values and per-axis impulse contribution
   logic                          s2_valid_ff, s2_valid_in;
   logic signed [COORD_WIDTH-1:0] s2_pos_ff [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] s2_vel_ff [NUM_AXES];
   logic [IMP_WIDTH-1:0]          s2_imp_ff [NUM_AXES];
   logic                          s2_last_ff;

   // stage 3: result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_WIDTH-1:0] rsp_pos_ff [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] rsp_vel_ff [NUM_AXES];
   logic [IMP_WIDTH-1:0]          rsp_imp_ff [NUM_AXES];
   logic                          rsp_last_ff;

   // running impulse sums
   logic [IMP_WIDTH-1:0] acc_ff  [NUM_AXES];
   logic [IMP_WIDTH-1:0] acc_in  [NUM_AXES];
   logic [IMP_WIDTH-1:0] acc_sum [NUM_AXES];

   // axis inputs and combinational stage-1 results
   logic signed [COORD_WIDTH-1:0] req_pos [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] req_vel [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] ax_pos  [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] ax_vel  [NUM_AXES];
   logic [IMP_WIDTH-1:0]          ax_imp  [NUM_AXES];

   // handshake between stages
   logic out_ready, s2_ready;
   logic s1_load, s2_load, out_load;

   assign req_pos[0] = req_pos_x;
   assign req_pos[1] = req_pos_y;
   assign req_pos[2] = req_pos_z;
   assign req_vel[0] = req_vel_x;
   assign req_vel[1] = req_vel_y;
   assign req_vel[2] = req_vel_z;

   // a stage can take a new item when empty or when its item moves on
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign req_ready = !s1_valid_ff || s2_ready;

   assign s1_load  = req_valid && req_ready;
   assign s2_load  = s1_valid_ff && s2_ready;
   assign out_load = s2_valid_ff && out_ready;

   assign s1_valid_in  = s1_load || (s1_valid_ff && !s2_load);
   assign s2_valid_in  = s2_load || (s2_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   // csr decode; writes past the last register are dropped
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         half_in[i] = half_ff[i];
      end
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BOX_HALF_X: half_in[0] = csr_wdata;
            CSR_BOX_HALF_Y: half_in[1] = csr_wdata;
            CSR_BOX_HALF_Z: half_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   // reflection and impulse product for each axis
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      bwri_axis #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_axis (
         .pos     (s1_pos_ff[a]),
         .vel     (s1_vel_ff[a]),
         .half    (half_ff[a]),
         .mass    (s1_mass_ff),
         .new_pos (ax_pos[a]),
         .new_vel (ax_vel[a]),
         .impulse (ax_imp[a])
      );
   end

   // last particle takes the sum out and restarts from zero
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         acc_sum[i] = sat_add_imp(acc_ff[i], s2_imp_ff[i]);
         acc_in[i]  = acc_ff[i];
         if (out_load) begin
            acc_in[i] = s2_last_ff ? '0 : acc_sum[i];
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            half_ff[i] <= HALF_RESET;
            acc_ff[i]  <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_AXES; i++) begin
            half_ff[i] <= half_in[i];
            acc_ff[i]  <= acc_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            s1_pos_ff[i] <= req_pos[i];
            s1_vel_ff[i] <= req_vel[i];
         end
         s1_mass_ff <= req_mass;
         s1_last_ff <= req_last_particle;
      end
      if (s2_load) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            s2_pos_ff[i] <= ax_pos[i];
            s2_vel_ff[i] <= ax_vel[i];
            s2_imp_ff[i] <= ax_imp[i];
         end
         s2_last_ff <= s1_last_ff;
      end
      if (out_load) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            rsp_pos_ff[i] <= s2_pos_ff[i];
            rsp_vel_ff[i] <= s2_vel_ff[i];
            rsp_imp_ff[i] <= s2_last_ff ? acc_sum[i] : '0;
         end
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_pos_x = rsp_pos_ff[0];
   assign rsp_new_pos_y = rsp_pos_ff[1];
   assign rsp_new_pos_z = rsp_pos_ff[2];
   assign rsp_new_vel_x = rsp_vel_ff[0];
   assign rsp_new_vel_y = rsp_vel_ff[1];
   assign rsp_new_vel_z = rsp_vel_ff[2];
   assign rsp_impulse_x = rsp_imp_ff[0];
   assign rsp_impulse_y = rsp_imp_ff[1];
   assign rsp_impulse_z = rsp_imp_ff[2];
   assign rsp_is_last   = rsp_last_ff;

   // totals only show on the last particle
   `BWRI_ASSERT_SAME(a_totals_only_last, clock, reset,
      rsp_valid_ff && !rsp_last_ff,
      rsp_imp_ff[0] == '0 && rsp_imp_ff[1] == '0 && rsp_imp_ff[2] == '0)

   // sums restart after the last particle leaves stage 2
   `BWRI_ASSERT_NEXT(a_acc_cleared, clock, reset,
      out_load && s2_last_ff,
      acc_ff[0] == '0 && acc_ff[1] == '0 && acc_ff[2] == '0)

   // an empty input stage never blocks the sender
   `BWRI_ASSERT_SAME(a_ready_when_empty, clock, reset,
      !s1_valid_ff, req_ready)

   // an item in stage 2 reaches the result register when it is free
   `BWRI_ASSERT_NEXT(a_s2_advances, clock, reset,
      s2_valid_ff && out_ready, rsp_valid_ff)

endmodule
